### design/a32fc_pkg.sv
// shared constants and types for the adler-32 frame checker
`timescale 1ns / 1ps

package a32fc_pkg;

    localparam int TAG_BYTES_MAX  = 8;
    localparam int POSITION_BITS  = 27;
    localparam int HEADER_BYTES   = 4;
    localparam int CHECKSUM_BYTES = 4;

    localparam int LEN_CFG_BITS = 27;
    localparam int TAG_LEN_BITS = 4;
    localparam int TAG_SEL_BITS = $clog2(TAG_BYTES_MAX) > 0 ? $clog2(TAG_BYTES_MAX) : 1;
    localparam int HDR_CNT_BITS = $clog2(HEADER_BYTES);

    localparam logic [15:0] ADLER_MOD = 16'd65521;

    localparam logic [31:0] POS_MASK = 32'((64'd1 << POSITION_BITS) - 64'd1);

    localparam logic [LEN_CFG_BITS-1:0] MIN_LEN_RESET = LEN_CFG_BITS'(4);
    localparam logic [LEN_CFG_BITS-1:0] MAX_LEN_RESET = LEN_CFG_BITS'(67108864);

    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 64;

    // register indexes, 8 bytes apart
    localparam logic [1:0] REG_TAG_LENGTH = 2'd0;
    localparam logic [1:0] REG_TAG_VALUE  = 2'd1;
    localparam logic [1:0] REG_MIN_LEN    = 2'd2;
    localparam logic [1:0] REG_MAX_LEN    = 2'd3;

    typedef enum logic [1:0] {
        ST_NO_ERROR       = 2'd0,
        ST_INVALID_LENGTH = 2'd1,
        ST_CHECKSUM_ERROR = 2'd2,
        ST_UNKNOWN_TYPE   = 2'd3
    } status_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

endpackage

### design/adler32_frame_checker.sv
// adler32_frame_checker: length-prefixed frame parser with adler-32 trailer check
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_byte
//   out       output     out_valid / out_ready  out_kind, out_byte, out_status, out_last
//   cfg       input      apb psel/penable       paddr, pwdata, prdata (64-bit data)
//
// one word is taken every cycle while in_ready is high; its result, if any, sits in the
// output register from the next cycle on, so throughput is one word per cycle while out does not stall.
// the output register is the only buffer: while it holds a word that is not taken,
// in_ready is low, so a stall on out holds the input side too.
// the adler update is two 17-bit add and conditional subtract steps in series.
// rst_n clears parser state, output register and all configuration to defaults.
// after an invalid_length verdict every word is consumed silently until reset.
`timescale 1ns / 1ps

module adler32_frame_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         in_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_kind,
    output logic [7:0]                         out_byte,
    output logic [1:0]                         out_status,
    output logic                               out_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [a32fc_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [a32fc_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [a32fc_pkg::PDATA_BITS-1:0]   prdata,
    output logic                               pready
);

    localparam int PB = a32fc_pkg::POSITION_BITS;
    localparam int LB = a32fc_pkg::LEN_CFG_BITS;
    localparam int HB = a32fc_pkg::HDR_CNT_BITS;
    localparam int SB = a32fc_pkg::TAG_SEL_BITS;
    localparam int TB = a32fc_pkg::TAG_LEN_BITS;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_HALT   = 2'd2
    } phase_t;

    // configuration
    logic [TB-1:0] tag_length_reg;
    logic [63:0]   tag_value_reg;
    logic [LB-1:0] min_len_reg;
    logic [LB-1:0] max_len_reg;

    // parser state
    phase_t        phase_reg, phase_next;
    logic [HB-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]   len_shift_reg, len_shift_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [15:0]   sum_lo_reg, sum_lo_next;
    logic [15:0]   sum_hi_reg, sum_hi_next;
    logic          tag_ok_reg, tag_ok_next;
    logic [31:0]   rx_sum_reg, rx_sum_next;

    // output register
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [7:0]         out_byte_reg;
    a32fc_pkg::status_t out_status_reg;
    logic               out_last_reg;

    logic               res_valid;
    logic               res_kind;
    logic [7:0]         res_byte;
    a32fc_pkg::status_t res_status;

    logic               accept;
    logic               cfg_wr;

    logic [TB-1:0]      tl;
    logic [31:0]        hdr_len;
    logic               len_bad;
    logic [PB-1:0]      body_len;
    logic               in_tag;
    logic               in_payload;
    logic               is_final;
    logic [SB-1:0]      tag_sel;
    logic [7:0]         tag_want;
    logic [16:0]        lo_sum;
    logic [15:0]        lo_mod;
    logic [16:0]        hi_sum;
    logic [15:0]        hi_mod;
    logic [31:0]        rx_full;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // register read back
    always_comb
    begin
        case (paddr[4:3])
            a32fc_pkg::REG_TAG_LENGTH: prdata = 64'(tag_length_reg);
            a32fc_pkg::REG_TAG_VALUE:  prdata = tag_value_reg;
            a32fc_pkg::REG_MIN_LEN:    prdata = 64'(min_len_reg);
            a32fc_pkg::REG_MAX_LEN:    prdata = 64'(max_len_reg);
            default:                   prdata = '0;
        endcase
    end

    // tag length above the maximum acts as the maximum
    assign tl = (tag_length_reg > TB'(a32fc_pkg::TAG_BYTES_MAX))
              ? TB'(a32fc_pkg::TAG_BYTES_MAX) : tag_length_reg;

    assign hdr_len = {len_shift_reg[23:0], in_byte};
    assign len_bad = hdr_len[31]
                  || (hdr_len < 32'(min_len_reg))
                  || (hdr_len > 32'(max_len_reg))
                  || (hdr_len < (32'(tl) + 32'(a32fc_pkg::CHECKSUM_BYTES)))
                  || (hdr_len > a32fc_pkg::POS_MASK);

    assign body_len   = len_shift_reg[PB-1:0];
    assign in_tag     = pos_reg < PB'(tl);
    assign in_payload = pos_reg < (body_len - PB'(a32fc_pkg::CHECKSUM_BYTES));
    assign is_final   = pos_reg == (body_len - PB'(1));

    // tag byte for this position, first byte in the top used slot
    assign tag_sel  = SB'(tl - TB'(1) - pos_reg[TB-1:0]);
    assign tag_want = tag_value_reg[8*tag_sel +: 8];

    // adler-32 byte step
    assign lo_sum = {1'b0, sum_lo_reg} + {9'd0, in_byte};
    assign lo_mod = (lo_sum >= {1'b0, a32fc_pkg::ADLER_MOD})
                  ? 16'(lo_sum - {1'b0, a32fc_pkg::ADLER_MOD}) : lo_sum[15:0];
    assign hi_sum = {1'b0, sum_hi_reg} + {1'b0, lo_mod};
    assign hi_mod = (hi_sum >= {1'b0, a32fc_pkg::ADLER_MOD})
                  ? 16'(hi_sum - {1'b0, a32fc_pkg::ADLER_MOD}) : hi_sum[15:0];

    assign rx_full = {rx_sum_reg[23:0], in_byte};

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_shift_next = len_shift_reg;
        pos_next       = pos_reg;
        sum_lo_next    = sum_lo_reg;
        sum_hi_next    = sum_hi_reg;
        tag_ok_next    = tag_ok_reg;
        rx_sum_next    = rx_sum_reg;
        res_valid      = 1'b0;
        res_kind       = a32fc_pkg::KIND_PAYLOAD;
        res_byte       = 8'd0;
        res_status     = a32fc_pkg::ST_NO_ERROR;

        case (phase_reg)
            PH_HEADER:
            begin
                len_shift_next = hdr_len;
                hdr_cnt_next   = HB'(hdr_cnt_reg + HB'(1));
                if (hdr_cnt_reg == HB'(a32fc_pkg::HEADER_BYTES - 1))
                begin
                    if (len_bad)
                    begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_kind   = a32fc_pkg::KIND_VERDICT;
                        res_status = a32fc_pkg::ST_INVALID_LENGTH;
                    end
                    else
                    begin
                        phase_next   = PH_BODY;
                        hdr_cnt_next = '0;
                        pos_next     = '0;
                    end
                end
            end
            PH_BODY:
            begin
                pos_next = PB'(pos_reg + PB'(1));
                if (in_tag)
                begin
                    if (tag_want != in_byte)
                        tag_ok_next = 1'b0;
                    sum_lo_next = lo_mod;
                    sum_hi_next = hi_mod;
                end
                else if (in_payload)
                begin
                    sum_lo_next = lo_mod;
                    sum_hi_next = hi_mod;
                    res_valid   = 1'b1;
                    res_byte    = in_byte;
                end
                else
                begin
                    rx_sum_next = rx_full;
                    if (is_final)
                    begin
                        res_valid = 1'b1;
                        res_kind  = a32fc_pkg::KIND_VERDICT;
                        if ({sum_hi_reg, sum_lo_reg} != rx_full)
                            res_status = a32fc_pkg::ST_CHECKSUM_ERROR;
                        else if (!tag_ok_reg)
                            res_status = a32fc_pkg::ST_UNKNOWN_TYPE;
                        else
                            res_status = a32fc_pkg::ST_NO_ERROR;
                        // back to a fresh frame
                        phase_next     = PH_HEADER;
                        hdr_cnt_next   = '0;
                        len_shift_next = '0;
                        pos_next       = '0;
                        sum_lo_next    = 16'd1;
                        sum_hi_next    = 16'd0;
                        tag_ok_next    = 1'b1;
                        rx_sum_next    = '0;
                    end
                end
            end
            default:
            begin
                // halted: words are consumed with no effect
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_length_reg <= '0;
            tag_value_reg  <= '0;
            min_len_reg    <= a32fc_pkg::MIN_LEN_RESET;
            max_len_reg    <= a32fc_pkg::MAX_LEN_RESET;
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            len_shift_reg  <= '0;
            pos_reg        <= '0;
            sum_lo_reg     <= 16'd1;
            sum_hi_reg     <= 16'd0;
            tag_ok_reg     <= 1'b1;
            rx_sum_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_byte_reg   <= '0;
            out_status_reg <= a32fc_pkg::ST_NO_ERROR;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[4:3])
                    a32fc_pkg::REG_TAG_LENGTH: tag_length_reg <= pwdata[TB-1:0];
                    a32fc_pkg::REG_TAG_VALUE:  tag_value_reg  <= pwdata;
                    a32fc_pkg::REG_MIN_LEN:    min_len_reg    <= pwdata[LB-1:0];
                    a32fc_pkg::REG_MAX_LEN:    max_len_reg    <= pwdata[LB-1:0];
                    default:                   ;
                endcase
            end

            if (accept)
            begin
                phase_reg     <= phase_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                len_shift_reg <= len_shift_next;
                pos_reg       <= pos_next;
                sum_lo_reg    <= sum_lo_next;
                sum_hi_reg    <= sum_hi_next;
                tag_ok_reg    <= tag_ok_next;
                rx_sum_reg    <= rx_sum_next;
            end

            if (in_ready)
            begin
                out_valid_reg  <= accept && res_valid;
                out_kind_reg   <= res_kind;
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
                out_last_reg   <= res_kind;
            end
        end
    end

    // halt is left only through reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("left halt without reset");

    // a length error always leaves the parser halted
    a_invalid_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg && out_status_reg == a32fc_pkg::ST_INVALID_LENGTH
        |-> phase_reg == PH_HALT)
        else $error("invalid_length verdict without halt");

    // verdict words carry last and a zero byte
    a_verdict_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg |-> out_last_reg && out_byte_reg == 8'd0)
        else $error("malformed verdict word");

    // payload words carry no status and no last
    a_payload_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_kind_reg
        |-> out_status_reg == a32fc_pkg::ST_NO_ERROR && !out_last_reg)
        else $error("malformed payload word");

    // body position stays inside the frame
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> pos_reg < body_len)
        else $error("body position past frame length");

endmodule
